@@ hw/rtl/hat_pkg.sv @@
// Types and constants shared by the handle attribute table.
// Depends on nothing; used by hat_store and handle_attribute_table.
package hat_pkg;

  localparam int unsigned DefEntries = 256;

  localparam logic [2:0] KindPutPart = 3'd0;
  localparam logic [2:0] KindPutProc = 3'd1;
  localparam logic [2:0] KindPutSize = 3'd2;
  localparam logic [2:0] KindGetSize = 3'd3;
  localparam logic [2:0] KindGetProc = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] proc_value;
    logic [15:0] width;
    logic [15:0] height;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        size_ok;
    logic [31:0] proc_out;
    logic [15:0] width_out;
    logic [15:0] height_out;
    logic        dropped;
  } rsp_t;

  typedef struct packed {
    logic [31:0] proc_val;
    logic [15:0] width;
    logic [15:0] height;
  } entry_t;

endpackage

@@ hw/rtl/handle_attribute_table.sv @@
// Top level of the handle attribute table: request FSM, scan and update logic.
// Depends on hat_pkg and hat_store.
//
// Use: a request enters on in_valid_i/in_ready_o with payload in_req_i (kind, key,
// proc_value, width, height); one response leaves on out_valid_o/out_ready_i with
// payload out_rsp_o. Every request, including unused kinds, gives exactly one response.
// Requests are handled one at a time. The key store is scanned from the oldest
// entry, one entry per cycle, through its registered read port, until the first
// hit or until all entries in use are checked; a miss checks every entry in use.
// Unused kinds skip the scan and go straight to the response register. in_ready_o
// rises again in the same cycle as out_valid_o, when the response is loaded.
// A put of a new key with all ENTRIES entries in use changes nothing and sets dropped.
// Reset empties the table at once (the entry count goes to zero); no clearing pass.
// When the receiver stalls, the response waits in the output register; the next
// request is still accepted and scanned, and holds in its final cycle until the
// output register is free.
module handle_attribute_table #(
  parameter int unsigned ENTRIES = hat_pkg::DefEntries
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hat_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hat_pkg::rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_e;

  state_e          state_q;
  hat_pkg::req_t   req_q;
  hat_pkg::rsp_t   out_q;
  logic            out_valid_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] scan_q;
  logic            chk_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            found_q;
  logic [IdxW-1:0] idx_q;

  logic            issue;
  logic            match;
  logic            out_free;
  logic            is_put;
  logic            full;
  logic            drop;
  logic            new_ins;
  logic            commit;
  logic [31:0]     key_rdata;
  logic [IdxW-1:0] key_raddr;
  logic [IdxW-1:0] ent_raddr;
  logic [IdxW-1:0] wr_addr;
  hat_pkg::entry_t ent_rdata;
  hat_pkg::entry_t old_ent;
  hat_pkg::entry_t new_ent;
  hat_pkg::rsp_t   rsp;

  assign issue     = (scan_q < cnt_q);
  assign match     = chk_q && (key_rdata == req_q.key);
  assign out_free  = !out_valid_q || out_ready_i;
  assign key_raddr = issue ? scan_q[IdxW-1:0] : '0;
  assign ent_raddr = (state_q == S_SCAN) ? chk_idx_q : idx_q;

  always_comb begin
    is_put  = (req_q.kind <= hat_pkg::KindPutSize);
    full    = (cnt_q == CntW'(ENTRIES));
    drop    = is_put && !found_q && full;
    new_ins = is_put && !found_q && !full;
    old_ent = found_q ? ent_rdata : '0;
    new_ent = old_ent;
    case (req_q.kind)
      hat_pkg::KindPutPart: begin
        if (req_q.proc_value != '0) new_ent.proc_val = req_q.proc_value;
        if (req_q.width != '0)      new_ent.width    = req_q.width;
        if (req_q.height != '0)     new_ent.height   = req_q.height;
      end
      hat_pkg::KindPutProc: begin
        new_ent.proc_val = req_q.proc_value;
      end
      hat_pkg::KindPutSize: begin
        new_ent.width  = req_q.width;
        new_ent.height = req_q.height;
      end
      default: begin
        new_ent = old_ent;
      end
    endcase
    wr_addr = found_q ? idx_q : cnt_q[IdxW-1:0];
    commit  = (state_q == S_RESOLVE) && out_free;

    rsp         = '0;
    rsp.hit     = found_q;
    rsp.dropped = drop;
    if (req_q.kind == hat_pkg::KindGetSize && found_q &&
        old_ent.width != '0 && old_ent.height != '0) begin
      rsp.size_ok    = 1'b1;
      rsp.width_out  = old_ent.width;
      rsp.height_out = old_ent.height;
    end
    if (req_q.kind == hat_pkg::KindGetProc && found_q) begin
      rsp.proc_out = old_ent.proc_val;
    end
  end

  hat_store #(
    .Entries (ENTRIES),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i       (clk_i),
    .key_we_i    (commit && new_ins),
    .key_waddr_i (wr_addr),
    .key_wdata_i (req_q.key),
    .key_raddr_i (key_raddr),
    .key_rdata_o (key_rdata),
    .ent_we_i    (commit && is_put && !drop),
    .ent_waddr_i (wr_addr),
    .ent_wdata_i (new_ent),
    .ent_raddr_i (ent_raddr),
    .ent_rdata_o (ent_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      chk_idx_q   <= '0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            scan_q  <= '0;
            chk_q   <= 1'b0;
            found_q <= 1'b0;
            state_q <= (in_req_i.kind <= hat_pkg::KindGetProc) ? S_SCAN : S_RESOLVE;
          end
        end
        S_SCAN: begin
          chk_q     <= issue;
          chk_idx_q <= scan_q[IdxW-1:0];
          if (issue) begin
            scan_q <= scan_q + 1'b1;
          end
          if (match) begin
            found_q <= 1'b1;
            idx_q   <= chk_idx_q;
            state_q <= S_RESOLVE;
          end else if (!issue) begin
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= rsp;
            if (new_ins) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
    else $error("entry count moved by more than one");

  a_drop_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.dropped |-> !out_rsp_o.hit)
    else $error("dropped request reported a hit");

  a_size_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.size_ok |->
      out_rsp_o.hit && out_rsp_o.width_out != '0 && out_rsp_o.height_out != '0)
    else $error("size_ok without a stored size");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");
`endif

endmodule

@@ hw/rtl/hat_store.sv @@
// Key store and attribute store of the handle attribute table.
// Synchronous (registered) read, one write port each; uses hat_pkg::entry_t.
module hat_store #(
  parameter int unsigned Entries = hat_pkg::DefEntries,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                 clk_i,
  input  logic                 key_we_i,
  input  logic [IdxW-1:0]      key_waddr_i,
  input  logic [31:0]          key_wdata_i,
  input  logic [IdxW-1:0]      key_raddr_i,
  output logic [31:0]          key_rdata_o,
  input  logic                 ent_we_i,
  input  logic [IdxW-1:0]      ent_waddr_i,
  input  hat_pkg::entry_t      ent_wdata_i,
  input  logic [IdxW-1:0]      ent_raddr_i,
  output hat_pkg::entry_t      ent_rdata_o
);

  logic [31:0]     key_mem [Entries];
  hat_pkg::entry_t ent_mem [Entries];

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_waddr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[key_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    ent_rdata_o <= ent_mem[ent_raddr_i];
  end

endmodule
